// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
// no dependencies; pulled in with an include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// invariant
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

// ----- hw/rtl/lfbkc_pkg.sv -----
// shared constants, types and helper functions of the key cache
// no dependencies; imported by the order keeper and the top level
package lfbkc_pkg;

   localparam int CAPACITY        = 16;
   localparam int KEY_BITS        = 32;
   localparam int SLOT_BITS       = $clog2(CAPACITY);
   localparam int COUNT_BITS      = $clog2(CAPACITY + 1);
   localparam int LIMIT_BITS      = 8;
   localparam int OP_BITS         = 3;
   localparam int STATUS_BITS     = 2;
   localparam int SLOT_FIELD_BITS = 4;
   localparam int KEY_FIELD_BITS  = 32;

   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_MISS    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_INVALID = 2'd2;

   localparam logic KIND_RESPONSE = 1'b0;
   localparam logic KIND_FLUSH    = 1'b1;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOOKUP    = 3'd0,
      OP_ENTER     = 3'd1,
      OP_INV_SLOT  = 3'd2,
      OP_INV_ALL   = 3'd3,
      OP_SET_LIMIT = 3'd4,
      OP_READ_KEY  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIND,
      ST_FETCH,
      ST_TAKE,
      ST_INSERT,
      ST_RESP
   } state_type;

   // one update of the recency order per cycle
   typedef struct packed {
      logic                 to_front;
      logic                 drop;
      logic                 insert;
      logic                 clear;
      logic [SLOT_BITS-1:0] slot;
   } order_cmd_type;

   typedef struct packed {
      logic                  rank_found;
      logic [SLOT_BITS-1:0]  rank_slot;
      logic                  free_found;
      logic [SLOT_BITS-1:0]  free_slot;
      logic [COUNT_BITS-1:0] count;
   } order_stat_type;

   // lowest set bit: {found, index}
   function automatic logic [SLOT_BITS:0] first_one(input logic [CAPACITY-1:0] vec);
      logic [SLOT_BITS:0] res;
      res = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (vec[i]) begin
            res = {1'b1, SLOT_BITS'(i)};
         end
      end
      return res;
   endfunction

   // zero or above capacity means capacity
   function automatic logic [COUNT_BITS-1:0] eff_limit(input logic [LIMIT_BITS-1:0] lim);
      logic [COUNT_BITS-1:0] res;
      if (lim == '0 || lim > LIMIT_BITS'(CAPACITY)) begin
         res = COUNT_BITS'(CAPACITY);
      end else begin
         res = COUNT_BITS'(lim);
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/lru_fifo_bounded_key_cache.sv -----
// top level of the bounded key cache: sequencer, key ram and result register
// depends on lfbkc_pkg, lfbkc_ram, lfbkc_order and assert_macros.svh
//
//  channel | direction | handshake            | carries
//  req     | in        | req_valid/req_ready  | operation, key, slot index, flags, limit
//  rsp     | out       | rsp_valid/rsp_ready  | response or flush notice word
//  csr     | in        | csr_wr_en            | lru mode bit
//
// lookup and enter scan the key ram one slot a cycle, then respond; an enter that misses
// inserts, and the tail goes first when the count is at the limit (rank search, ram read,
// notice). read key and invalidate slot read the slot, or respond at once for a slot index
// that is not valid; invalidate all and set limit search, read and drop each flushed entry
// in turn. one request is in flight at a time; req_ready is high only while the sequencer
// idles. synchronous reset clears order state and limit and sets lru mode, not the key ram;
// the sequencer pauses at each word it sends while the result register is full.
`include "assert_macros.svh"

module lru_fifo_bounded_key_cache
   import lfbkc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OP_BITS-1:0]         req_operation,
   input  logic [KEY_FIELD_BITS-1:0]  req_key,
   input  logic [SLOT_FIELD_BITS-1:0] req_slot_index,
   input  logic                       req_report_flushed,
   input  logic [LIMIT_BITS-1:0]      req_new_limit,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_kind,
   output logic [STATUS_BITS-1:0]     rsp_status,
   output logic [SLOT_FIELD_BITS-1:0] rsp_slot,
   output logic                       rsp_is_new,
   output logic [KEY_FIELD_BITS-1:0]  rsp_result_key,
   output logic [COUNT_BITS-1:0]      rsp_entry_total,
   output logic [LIMIT_BITS-1:0]      rsp_limit_now,
   output logic                       rsp_last,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data
);

   // sequencer state and latched request
   state_type                  state_ff, state_in;
   logic [OP_BITS-1:0]         op_ff, op_in;
   logic [KEY_BITS-1:0]        key_ff, key_in;
   logic                       report_ff, report_in;
   logic [LIMIT_BITS-1:0]      limit_ff, limit_in;
   logic                       lru_ff;

   // key scan pipeline: address issued, then compared in the next cycle
   logic [COUNT_BITS-1:0]      scan_ff, scan_in;
   logic                       cmp_live_ff, cmp_live_in;
   logic [SLOT_BITS-1:0]       cmp_slot_ff, cmp_slot_in;
   logic [SLOT_BITS-1:0]       tgt_ff, tgt_in;

   // pending response fields
   logic [STATUS_BITS-1:0]     res_status_ff, res_status_in;
   logic [SLOT_FIELD_BITS-1:0] res_slot_ff, res_slot_in;
   logic                       res_new_ff, res_new_in;
   logic [KEY_BITS-1:0]        res_key_ff, res_key_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff;
   logic [STATUS_BITS-1:0]     rsp_status_ff;
   logic [SLOT_FIELD_BITS-1:0] rsp_slot_ff;
   logic                       rsp_is_new_ff;
   logic [KEY_BITS-1:0]        rsp_key_ff;
   logic [COUNT_BITS-1:0]      rsp_total_ff;
   logic [LIMIT_BITS-1:0]      rsp_limit_ff;
   logic                       rsp_last_ff;

   // word being loaded into the result register
   logic                       emit;
   logic                       em_kind;
   logic [STATUS_BITS-1:0]     em_status;
   logic [SLOT_FIELD_BITS-1:0] em_slot;
   logic                       em_new;
   logic [KEY_BITS-1:0]        em_key;
   logic [COUNT_BITS-1:0]      em_total;
   logic                       em_last;

   // ram and order keeper
   logic                       ram_wr_en;
   logic [SLOT_BITS-1:0]       ram_wr_addr;
   logic                       ram_rd_en;
   logic [SLOT_BITS-1:0]       ram_rd_addr;
   logic [KEY_BITS-1:0]        ram_rd_data;
   order_cmd_type              ocmd;
   order_stat_type             ostat;
   logic [CAPACITY-1:0]        valid_vec;
   logic [COUNT_BITS-1:0]      find_target;

   // shared decisions
   logic                       accept;
   logic                       emit_ok;
   logic                       scan_issue;
   logic                       scan_hit;
   logic                       scan_end;
   logic [COUNT_BITS-1:0]      lim_eff;
   logic                       evict_need;
   logic                       find_go;
   logic [SLOT_BITS-1:0]       req_idx;
   logic                       idx_ok;

   lfbkc_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lfbkc_order u_order (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ocmd),
      .target    (find_target),
      .valid_vec (valid_vec),
      .stat      (ostat)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign emit_ok    = !rsp_valid_ff || rsp_ready;
   // single shared comparator walks the key ram
   assign scan_issue = scan_ff < COUNT_BITS'(CAPACITY);
   assign scan_hit   = cmp_live_ff && valid_vec[cmp_slot_ff] && (ram_rd_data == key_ff);
   assign scan_end   = scan_hit || !scan_issue;
   assign lim_eff    = eff_limit(limit_ff);
   assign evict_need = ostat.count >= lim_eff;
   assign req_idx    = SLOT_BITS'(req_slot_index);
   assign idx_ok     = (32'(req_slot_index) < CAPACITY) && valid_vec[req_idx];

   // rank wanted by the tail, trim or flush-all search
   always_comb begin
      unique case (op_ff)
         OP_ENTER:     find_target = ostat.count - 1'b1;
         OP_SET_LIMIT: find_target = lim_eff;
         default:      find_target = '0;
      endcase
   end

   always_comb begin
      unique case (op_ff)
         OP_ENTER:     find_go = ostat.rank_found;
         OP_INV_ALL:   find_go = (ostat.count != '0) && ostat.rank_found;
         OP_SET_LIMIT: find_go = (ostat.count > lim_eff) && ostat.rank_found;
         default:      find_go = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation) inside
                  OP_LOOKUP, OP_ENTER:     state_in = ST_SCAN;
                  OP_INV_SLOT, OP_READ_KEY: state_in = idx_ok ? ST_FETCH : ST_RESP;
                  OP_INV_ALL, OP_SET_LIMIT: state_in = ST_FIND;
                  default:                  state_in = ST_RESP;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               if (scan_hit || op_ff != OP_ENTER) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = evict_need ? ST_FIND : ST_INSERT;
               end
            end
         end
         ST_FIND: begin
            if (find_go) begin
               state_in = ST_FETCH;
            end else if (op_ff == OP_ENTER) begin
               state_in = ST_INSERT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_FETCH: state_in = ST_TAKE;
         ST_TAKE: begin
            unique case (op_ff)
               OP_ENTER:     state_in = emit_ok ? ST_INSERT : ST_TAKE;
               OP_SET_LIMIT: state_in = emit_ok ? ST_FIND : ST_TAKE;
               OP_INV_ALL:   state_in = (!report_ff || emit_ok) ? ST_FIND : ST_TAKE;
               default:      state_in = ST_RESP;
            endcase
         end
         ST_INSERT: state_in = ST_RESP;
         ST_RESP:   state_in = emit_ok ? ST_IDLE : ST_RESP;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      report_in     = report_ff;
      limit_in      = limit_ff;
      scan_in       = scan_ff;
      cmp_live_in   = 1'b0;
      cmp_slot_in   = cmp_slot_ff;
      tgt_in        = tgt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_new_in    = res_new_ff;
      res_key_in    = res_key_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = ostat.free_slot;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = tgt_ff;
      ocmd          = '0;
      emit          = 1'b0;
      em_kind       = KIND_RESPONSE;
      em_status     = STATUS_OK;
      em_slot       = '0;
      em_new        = 1'b0;
      em_key        = '0;
      em_total      = ostat.count;
      em_last       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in         = req_operation;
               key_in        = KEY_BITS'(req_key);
               report_in     = req_report_flushed;
               scan_in       = '0;
               tgt_in        = req_idx;
               res_status_in = STATUS_OK;
               res_slot_in   = '0;
               res_new_in    = 1'b0;
               res_key_in    = '0;
               if (req_operation == OP_SET_LIMIT) begin
                  limit_in = req_new_limit;
               end
               if (req_operation == OP_INV_SLOT || req_operation == OP_READ_KEY) begin
                  res_slot_in   = req_slot_index;
                  res_status_in = idx_ok ? STATUS_OK : STATUS_INVALID;
               end
            end
         end
         ST_SCAN: begin
            ram_rd_en   = scan_issue;
            ram_rd_addr = scan_ff[SLOT_BITS-1:0];
            cmp_live_in = scan_issue;
            cmp_slot_in = scan_ff[SLOT_BITS-1:0];
            if (scan_issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (scan_end) begin
               res_key_in = key_ff;
               if (scan_hit) begin
                  res_status_in = STATUS_OK;
                  res_slot_in   = SLOT_FIELD_BITS'(cmp_slot_ff);
                  // enter always refreshes; lookup only in lru mode
                  ocmd.to_front = (op_ff == OP_ENTER) || lru_ff;
                  ocmd.slot     = cmp_slot_ff;
               end else begin
                  res_status_in = STATUS_MISS;
                  res_slot_in   = '0;
               end
            end
         end
         ST_FIND: begin
            if (find_go) begin
               tgt_in = ostat.rank_slot;
            end else if (op_ff == OP_INV_ALL) begin
               ocmd.clear = 1'b1;
            end
         end
         ST_FETCH: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = tgt_ff;
         end
         ST_TAKE: begin
            ocmd.slot = tgt_ff;
            em_kind   = KIND_FLUSH;
            em_slot   = SLOT_FIELD_BITS'(tgt_ff);
            em_key    = ram_rd_data;
            em_total  = ostat.count - 1'b1;
            unique case (op_ff) inside
               OP_ENTER, OP_SET_LIMIT: begin
                  if (emit_ok) begin
                     emit      = 1'b1;
                     ocmd.drop = 1'b1;
                  end
               end
               OP_INV_ALL: begin
                  if (!report_ff || emit_ok) begin
                     emit      = report_ff;
                     ocmd.drop = 1'b1;
                  end
               end
               OP_INV_SLOT: begin
                  ocmd.drop  = 1'b1;
                  res_key_in = ram_rd_data;
               end
               default: begin
                  res_key_in = ram_rd_data;
               end
            endcase
         end
         ST_INSERT: begin
            if (ostat.free_found) begin
               ocmd.insert   = 1'b1;
               ocmd.slot     = ostat.free_slot;
               ram_wr_en     = 1'b1;
               res_status_in = STATUS_OK;
               res_slot_in   = SLOT_FIELD_BITS'(ostat.free_slot);
               res_new_in    = 1'b1;
            end else begin
               res_status_in = STATUS_MISS;
               res_slot_in   = '0;
               res_new_in    = 1'b0;
            end
         end
         ST_RESP: begin
            if (emit_ok) begin
               emit      = 1'b1;
               em_status = res_status_ff;
               em_slot   = res_slot_ff;
               em_new    = res_new_ff;
               em_key    = res_key_ff;
               em_last   = 1'b1;
            end
         end
         default: begin
            ocmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lru_ff       <= 1'b1;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
         cmp_live_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
         cmp_live_ff  <= cmp_live_in;
         if (csr_wr_en) begin
            lru_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      report_ff     <= report_in;
      cmp_slot_ff   <= cmp_slot_in;
      tgt_ff        <= tgt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_new_ff    <= res_new_in;
      res_key_ff    <= res_key_in;
      if (emit) begin
         rsp_kind_ff   <= em_kind;
         rsp_status_ff <= em_status;
         rsp_slot_ff   <= em_slot;
         rsp_is_new_ff <= em_new;
         rsp_key_ff    <= em_key;
         rsp_total_ff  <= em_total;
         rsp_limit_ff  <= limit_ff;
         rsp_last_ff   <= em_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_is_new      = rsp_is_new_ff;
   assign rsp_result_key  = KEY_FIELD_BITS'(rsp_key_ff);
   assign rsp_entry_total = rsp_total_ff;
   assign rsp_limit_now   = rsp_limit_ff;
   assign rsp_last        = rsp_last_ff;

   `ASSERT_IMPLIES(a_no_overwrite, clock, reset,
      rsp_valid_ff && !rsp_ready, !emit, "result word overwritten before it was taken")
   `ASSERT_NEXT(a_busy_after_accept, clock, reset,
      accept, !req_ready, "sequencer still ready right after taking a word")
   `ASSERT_IMPLIES(a_single_order_cmd, clock, reset, ocmd.drop || ocmd.insert,
      !ocmd.to_front && !ocmd.clear, "conflicting recency updates in one cycle")

endmodule

// ----- hw/rtl/lfbkc_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module lfbkc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lfbkc_order.sv -----
// slot valid bits, recency ranks and entry count of the key cache
// depends on lfbkc_pkg and assert_macros.svh
`include "assert_macros.svh"

module lfbkc_order
   import lfbkc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  order_cmd_type         cmd,
   input  logic [COUNT_BITS-1:0] target,
   output logic [CAPACITY-1:0]   valid_vec,
   output order_stat_type        stat
);

   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [SLOT_BITS-1:0]  rank_ff [CAPACITY];
   logic [SLOT_BITS-1:0]  rank_in [CAPACITY];
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SLOT_BITS-1:0]  sel_rank;
   logic [CAPACITY-1:0]   rank_match;
   logic [SLOT_BITS:0]    rank_pick;
   logic [SLOT_BITS:0]    free_pick;

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      count_in = count_ff;
      sel_rank = rank_ff[cmd.slot];
      if (cmd.clear) begin
         valid_in = '0;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_in[i] = '0;
         end
         count_in = '0;
      end else if (cmd.drop) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (valid_ff[i] && rank_ff[i] > sel_rank) begin
               rank_in[i] = rank_ff[i] - 1'b1;
            end
         end
         valid_in[cmd.slot] = 1'b0;
         if (count_ff != '0) begin
            count_in = count_ff - 1'b1;
         end
      end else if (cmd.insert) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
         valid_in[cmd.slot] = 1'b1;
         rank_in[cmd.slot]  = '0;
         count_in           = count_ff + 1'b1;
      end else if (cmd.to_front) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (valid_ff[i] && rank_ff[i] < sel_rank) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
         rank_in[cmd.slot] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         rank_ff  <= rank_in;
      end
   end

   // slot holding a given rank, and lowest free slot
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         rank_match[i] = valid_ff[i] && (COUNT_BITS'(rank_ff[i]) == target);
      end
   end

   assign rank_pick = first_one(rank_match);
   assign free_pick = first_one(~valid_ff);

   assign stat.rank_found = rank_pick[SLOT_BITS];
   assign stat.rank_slot  = rank_pick[SLOT_BITS-1:0];
   assign stat.free_found = free_pick[SLOT_BITS];
   assign stat.free_slot  = free_pick[SLOT_BITS-1:0];
   assign stat.count      = count_ff;
   assign valid_vec       = valid_ff;

   `ASSERT_ALWAYS(a_count_matches, clock, reset,
      count_ff == COUNT_BITS'($countones(valid_ff)), "entry count out of step with valid bits")
   `ASSERT_IMPLIES(a_insert_free, clock, reset,
      cmd.insert, !valid_ff[cmd.slot], "insert into a slot already in use")
   `ASSERT_NEXT(a_drop_counts, clock, reset, cmd.drop && valid_ff[cmd.slot],
      count_ff == $past(count_ff) - 1'b1, "drop did not reduce the entry count")

endmodule
